/* src/gknms_pkg.sv */
package gknms_pkg;

    localparam int XW   = 9;
    localparam int YW   = 9;
    localparam int RW   = 16;
    localparam int RADW = 4;
    localparam int CFGW = 10;
    localparam int IDXW = 2;
    // signed width for coordinate math (clip bounds, window corners)
    localparam int CW   = 14;

    typedef logic [1:0] cell_t;
    localparam cell_t CELL_EMPTY  = 2'd0;
    localparam cell_t CELL_MARKED = 2'd1;
    localparam cell_t CELL_KEPT   = 2'd2;

    localparam logic [IDXW-1:0] REG_RADIUS = 2'd0;
    localparam logic [IDXW-1:0] REG_WIDTH  = 2'd1;
    localparam logic [IDXW-1:0] REG_HEIGHT = 2'd2;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    typedef struct packed {
        logic [XW-1:0] x;
        logic [YW-1:0] y;
        logic [RW-1:0] r;
    } point_t;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b00_0000_0001,
        ST_CLEAR  = 10'b00_0000_0010,
        ST_MARK   = 10'b00_0000_0100,
        ST_SELECT = 10'b00_0000_1000,
        ST_TEST   = 10'b00_0001_0000,
        ST_SQUARE = 10'b00_0010_0000,
        ST_KEEP   = 10'b00_0100_0000,
        ST_SCAN   = 10'b00_1000_0000,
        ST_LOOK   = 10'b01_0000_0000,
        ST_DONE   = 10'b10_0000_0000
    } state_t;

endpackage

/* src/gknms_ram.sv */
module gknms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* src/grid_keypoint_nms_core.sv */
// Load: a transfer is taken whenever the core is idle; the load marked last then runs
//   suppression: mark the points, take them in rank order and keep each one still
//   marked, clearing its window. Fetch: scan the grid up to the next survivor, look
//   up its response and load the output register; with none left, an empty result.
// Reset (aresetn low, synchronous) clears control state and sets the registers
//   to radius 4, width 512, height 512; the grid is swept clean before each suppression.
module grid_keypoint_nms_core #(
    parameter int MAX_KEYPOINTS = 1024,
    parameter int MAX_WIDTH     = 512,
    parameter int MAX_HEIGHT    = 512
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [gknms_pkg::IDXW-1:0]    cfg_wr_index,
    input  logic [gknms_pkg::CFGW-1:0]    cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_opcode,
    input  logic [gknms_pkg::XW-1:0]      s_pos_x,
    input  logic [gknms_pkg::YW-1:0]      s_pos_y,
    input  logic [gknms_pkg::RW-1:0]      s_response,
    input  logic                          s_last,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_has_survivor,
    output logic [gknms_pkg::XW-1:0]      m_kept_x,
    output logic [gknms_pkg::YW-1:0]      m_kept_y,
    output logic [gknms_pkg::RW-1:0]      m_kept_response,
    output logic                          m_final_survivor,
    output logic                          m_overflowed
);

    localparam int CW   = gknms_pkg::CW;
    localparam int RW   = gknms_pkg::RW;
    localparam int KW   = (MAX_KEYPOINTS > 1) ? $clog2(MAX_KEYPOINTS) : 1;
    localparam int CNTW = $clog2(MAX_KEYPOINTS + 1);
    localparam int GRID = MAX_WIDTH * MAX_HEIGHT;
    localparam int GAW  = $clog2(GRID);
    localparam int SAW  = $clog2(GRID + 1);
    localparam int SXW  = $clog2(MAX_WIDTH);
    localparam int SYW  = $clog2(MAX_HEIGHT);
    localparam int KEYW = RW + KW;

    // grid cell address of (row, column)
    function automatic logic [GAW-1:0] cell_addr(input logic [CW-1:0] y,
                                                 input logic [CW-1:0] x);
        return GAW'(int'(y) * MAX_WIDTH + int'(x));
    endfunction

    gknms_pkg::state_t state_reg, state_next;

    logic [gknms_pkg::RADW-1:0] rad_reg, rad_next;
    logic [gknms_pkg::CFGW-1:0] width_reg, width_next;
    logic [gknms_pkg::CFGW-1:0] height_reg, height_next;

    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [CNTW-1:0] surv_reg, surv_next;
    logic [CNTW-1:0] idx_reg, idx_next;
    logic            drop_reg, drop_next;
    logic            fetching_reg, fetching_next;
    logic            pend_reg, pend_next;

    logic [SAW-1:0]  scan_reg, scan_next;
    logic [SXW-1:0]  sx_reg, sx_next;
    logic [SYW-1:0]  sy_reg, sy_next;

    logic            have_prev_reg, have_prev_next;
    logic [KEYW-1:0] prev_key_reg, prev_key_next;
    logic            best_found_reg, best_found_next;
    logic [KEYW-1:0] best_key_reg, best_key_next;
    logic [CW-1:0]   best_x_reg, best_x_next;
    logic [CW-1:0]   best_y_reg, best_y_next;

    logic [CW-1:0]   x0_reg, x0_next;
    logic [CW-1:0]   x1_reg, x1_next;
    logic [CW-1:0]   y1_reg, y1_next;
    logic [CW-1:0]   xx_reg, xx_next;
    logic [CW-1:0]   yy_reg, yy_next;

    logic [CW-1:0]   fx_reg, fx_next;
    logic [CW-1:0]   fy_reg, fy_next;
    logic [RW-1:0]   look_r_reg, look_r_next;
    logic            res_has_reg, res_has_next;
    logic            res_final_reg, res_final_next;

    logic                         m_valid_reg, m_valid_next;
    logic                         m_has_reg, m_has_next;
    logic [gknms_pkg::XW-1:0]     m_x_reg, m_x_next;
    logic [gknms_pkg::YW-1:0]     m_y_reg, m_y_next;
    logic [RW-1:0]                m_r_reg, m_r_next;
    logic                         m_final_reg, m_final_next;
    logic                         m_ovf_reg, m_ovf_next;

    // point store and mark grid
    logic                      store_we;
    logic [KW-1:0]             store_wa;
    gknms_pkg::point_t         store_wd, store_rd;
    logic                      grid_we;
    logic [GAW-1:0]            grid_wa, grid_ra;
    gknms_pkg::cell_t          grid_wd, grid_rd;

    gknms_ram #(.WIDTH($bits(gknms_pkg::point_t)), .DEPTH(MAX_KEYPOINTS)) u_store (
        .aclk    (aclk),
        .wr_en   (store_we),
        .wr_addr (store_wa),
        .wr_data (store_wd),
        .rd_addr (idx_reg[KW-1:0]),
        .rd_data (store_rd)
    );

    gknms_ram #(.WIDTH($bits(gknms_pkg::cell_t)), .DEPTH(GRID)) u_grid (
        .aclk    (aclk),
        .wr_en   (grid_we),
        .wr_addr (grid_wa),
        .wr_data (grid_wd),
        .rd_addr (grid_ra),
        .rd_data (grid_rd)
    );

    // width and height saturated to the grid
    logic [CW-1:0] effw, effh;
    assign effw = (CW'(width_reg) > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(width_reg);
    assign effh = (CW'(height_reg) > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : CW'(height_reg);

    assign s_ready = (state_reg == gknms_pkg::ST_IDLE);

    logic            load_ok;
    logic [CNTW-1:0] base_cnt;
    logic [KEYW-1:0] cand_key;
    logic signed [CW-1:0] px, py, rs, lo_x, lo_y, hi_x, hi_y, wm1, hm1;
    logic [CW-1:0]   cx0, cx1, cy0, cy1;

    assign base_cnt = fetching_reg ? '0 : cnt_reg;
    assign load_ok  = (CW'(s_pos_x) < effw) && (CW'(s_pos_y) < effh)
                      && (base_cnt < CNTW'(MAX_KEYPOINTS));
    assign cand_key = {store_rd.r, ~idx_reg[KW-1:0]};

    // clip window around the selected point
    assign px   = $signed(best_x_reg);
    assign py   = $signed(best_y_reg);
    assign rs   = $signed(CW'(rad_reg));
    assign lo_x = px - rs;
    assign lo_y = py - rs;
    assign hi_x = px + rs;
    assign hi_y = py + rs;
    assign wm1  = $signed(effw) - CW'(1);
    assign hm1  = $signed(effh) - CW'(1);
    assign cx0  = (lo_x < 0) ? '0 : lo_x;
    assign cy0  = (lo_y < 0) ? '0 : lo_y;
    assign cx1  = (hi_x > wm1) ? wm1 : hi_x;
    assign cy1  = (hi_y > hm1) ? hm1 : hi_y;

    always_comb begin
        state_next      = state_reg;
        rad_next        = rad_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        cnt_next        = cnt_reg;
        surv_next       = surv_reg;
        idx_next        = idx_reg;
        drop_next       = drop_reg;
        fetching_next   = fetching_reg;
        pend_next       = pend_reg;
        scan_next       = scan_reg;
        sx_next         = sx_reg;
        sy_next         = sy_reg;
        have_prev_next  = have_prev_reg;
        prev_key_next   = prev_key_reg;
        best_found_next = best_found_reg;
        best_key_next   = best_key_reg;
        best_x_next     = best_x_reg;
        best_y_next     = best_y_reg;
        x0_next         = x0_reg;
        x1_next         = x1_reg;
        y1_next         = y1_reg;
        xx_next         = xx_reg;
        yy_next         = yy_reg;
        fx_next         = fx_reg;
        fy_next         = fy_reg;
        look_r_next     = look_r_reg;
        res_has_next    = res_has_reg;
        res_final_next  = res_final_reg;
        m_valid_next    = m_valid_reg;
        m_has_next      = m_has_reg;
        m_x_next        = m_x_reg;
        m_y_next        = m_y_reg;
        m_r_next        = m_r_reg;
        m_final_next    = m_final_reg;
        m_ovf_next      = m_ovf_reg;

        store_we = 1'b0;
        store_wa = base_cnt[KW-1:0];
        store_wd = '{x: s_pos_x, y: s_pos_y, r: s_response};
        grid_we  = 1'b0;
        grid_wa  = scan_reg[GAW-1:0];
        grid_wd  = gknms_pkg::CELL_EMPTY;
        grid_ra  = scan_reg[GAW-1:0];

        if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                gknms_pkg::REG_RADIUS: rad_next    = cfg_wr_data[gknms_pkg::RADW-1:0];
                gknms_pkg::REG_WIDTH:  width_next  = cfg_wr_data;
                gknms_pkg::REG_HEIGHT: height_next = cfg_wr_data;
                default: ;
            endcase
        end

        // retire the output register on its transfer
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            gknms_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_opcode == gknms_pkg::OP_LOAD) begin
                        // a load after suppression opens a new frame
                        if (fetching_reg) begin
                            surv_next     = '0;
                            scan_next     = '0;
                            sx_next       = '0;
                            sy_next       = '0;
                            fetching_next = 1'b0;
                            drop_next     = 1'b0;
                        end
                        if (load_ok) begin
                            store_we = 1'b1;
                            cnt_next = base_cnt + CNTW'(1);
                        end else begin
                            cnt_next  = base_cnt;
                            drop_next = 1'b1;
                        end
                        if (s_last) begin
                            state_next = gknms_pkg::ST_CLEAR;
                            scan_next  = '0;
                            surv_next  = '0;
                        end
                    end else begin
                        res_has_next   = 1'b0;
                        res_final_next = 1'b0;
                        pend_next      = 1'b0;
                        if (!fetching_reg || surv_reg == '0) begin
                            state_next = gknms_pkg::ST_DONE;
                        end else begin
                            state_next = gknms_pkg::ST_SCAN;
                        end
                    end
                end
            end

            gknms_pkg::ST_CLEAR: begin
                grid_we = 1'b1;
                if (scan_reg == SAW'(GRID - 1)) begin
                    scan_next  = '0;
                    idx_next   = '0;
                    pend_next  = 1'b0;
                    state_next = gknms_pkg::ST_MARK;
                end else begin
                    scan_next = scan_reg + SAW'(1);
                end
            end

            gknms_pkg::ST_MARK: begin
                if (idx_reg == cnt_reg) begin
                    idx_next        = '0;
                    pend_next       = 1'b0;
                    have_prev_next  = 1'b0;
                    best_found_next = 1'b0;
                    state_next      = gknms_pkg::ST_SELECT;
                end else if (!pend_reg) begin
                    pend_next = 1'b1;
                end else begin
                    grid_we   = 1'b1;
                    grid_wa   = cell_addr(CW'(store_rd.y), CW'(store_rd.x));
                    grid_wd   = gknms_pkg::CELL_MARKED;
                    pend_next = 1'b0;
                    idx_next  = idx_reg + CNTW'(1);
                end
            end

            gknms_pkg::ST_SELECT: begin
                // next point in rank order: highest key below the previous one
                if (idx_reg == cnt_reg) begin
                    if (best_found_reg) begin
                        have_prev_next = 1'b1;
                        prev_key_next  = best_key_reg;
                        pend_next      = 1'b0;
                        state_next     = gknms_pkg::ST_TEST;
                    end else begin
                        fetching_next = 1'b1;
                        scan_next     = '0;
                        sx_next       = '0;
                        sy_next       = '0;
                        state_next    = gknms_pkg::ST_IDLE;
                    end
                end else if (!pend_reg) begin
                    pend_next = 1'b1;
                end else begin
                    if ((!have_prev_reg || cand_key < prev_key_reg)
                        && (!best_found_reg || cand_key > best_key_reg)) begin
                        best_found_next = 1'b1;
                        best_key_next   = cand_key;
                        best_x_next     = CW'(store_rd.x);
                        best_y_next     = CW'(store_rd.y);
                    end
                    pend_next = 1'b0;
                    idx_next  = idx_reg + CNTW'(1);
                end
            end

            gknms_pkg::ST_TEST: begin
                grid_ra = cell_addr(best_y_reg, best_x_reg);
                if (!pend_reg) begin
                    pend_next = 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (grid_rd == gknms_pkg::CELL_MARKED) begin
                        x0_next = cx0;
                        x1_next = cx1;
                        y1_next = cy1;
                        xx_next = cx0;
                        yy_next = cy0;
                        if ($signed(cx0) > $signed(cx1) || $signed(cy0) > $signed(cy1)) begin
                            state_next = gknms_pkg::ST_KEEP;
                        end else begin
                            state_next = gknms_pkg::ST_SQUARE;
                        end
                    end else begin
                        idx_next        = '0;
                        best_found_next = 1'b0;
                        state_next      = gknms_pkg::ST_SELECT;
                    end
                end
            end

            gknms_pkg::ST_SQUARE: begin
                grid_we = 1'b1;
                grid_wa = cell_addr(yy_reg, xx_reg);
                grid_wd = gknms_pkg::CELL_EMPTY;
                if (xx_reg == x1_reg) begin
                    xx_next = x0_reg;
                    if (yy_reg == y1_reg) begin
                        state_next = gknms_pkg::ST_KEEP;
                    end else begin
                        yy_next = yy_reg + CW'(1);
                    end
                end else begin
                    xx_next = xx_reg + CW'(1);
                end
            end

            gknms_pkg::ST_KEEP: begin
                grid_we         = 1'b1;
                grid_wa         = cell_addr(best_y_reg, best_x_reg);
                grid_wd         = gknms_pkg::CELL_KEPT;
                surv_next       = surv_reg + CNTW'(1);
                idx_next        = '0;
                pend_next       = 1'b0;
                best_found_next = 1'b0;
                state_next      = gknms_pkg::ST_SELECT;
            end

            gknms_pkg::ST_SCAN: begin
                if (!pend_reg) begin
                    if (scan_reg == SAW'(GRID)) begin
                        // grid exhausted: drop the remaining count
                        surv_next  = '0;
                        state_next = gknms_pkg::ST_DONE;
                    end else begin
                        pend_next = 1'b1;
                    end
                end else begin
                    pend_next = 1'b0;
                    scan_next = scan_reg + SAW'(1);
                    if (sx_reg == SXW'(MAX_WIDTH - 1)) begin
                        sx_next = '0;
                        sy_next = sy_reg + SYW'(1);
                    end else begin
                        sx_next = sx_reg + SXW'(1);
                    end
                    if (grid_rd == gknms_pkg::CELL_KEPT) begin
                        fx_next     = CW'(sx_reg);
                        fy_next     = CW'(sy_reg);
                        look_r_next = '0;
                        idx_next    = '0;
                        state_next  = gknms_pkg::ST_LOOK;
                    end
                end
            end

            gknms_pkg::ST_LOOK: begin
                // response of the kept point: best score at that position
                if (idx_reg == cnt_reg) begin
                    res_has_next   = 1'b1;
                    res_final_next = (surv_reg == CNTW'(1));
                    surv_next      = surv_reg - CNTW'(1);
                    state_next     = gknms_pkg::ST_DONE;
                end else if (!pend_reg) begin
                    pend_next = 1'b1;
                end else begin
                    if (CW'(store_rd.x) == fx_reg && CW'(store_rd.y) == fy_reg
                        && store_rd.r > look_r_reg) begin
                        look_r_next = store_rd.r;
                    end
                    pend_next = 1'b0;
                    idx_next  = idx_reg + CNTW'(1);
                end
            end

            gknms_pkg::ST_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_has_next   = res_has_reg;
                    m_x_next     = res_has_reg ? gknms_pkg::XW'(fx_reg) : '0;
                    m_y_next     = res_has_reg ? gknms_pkg::YW'(fy_reg) : '0;
                    m_r_next     = res_has_reg ? look_r_reg : '0;
                    m_final_next = res_has_reg & res_final_reg;
                    m_ovf_next   = drop_reg;
                    state_next   = gknms_pkg::ST_IDLE;
                end
            end

            default: state_next = gknms_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= gknms_pkg::ST_IDLE;
            rad_reg        <= gknms_pkg::RADW'(4);
            width_reg      <= gknms_pkg::CFGW'(512);
            height_reg     <= gknms_pkg::CFGW'(512);
            cnt_reg        <= '0;
            surv_reg       <= '0;
            idx_reg        <= '0;
            drop_reg       <= 1'b0;
            fetching_reg   <= 1'b0;
            pend_reg       <= 1'b0;
            scan_reg       <= '0;
            sx_reg         <= '0;
            sy_reg         <= '0;
            have_prev_reg  <= 1'b0;
            best_found_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            rad_reg        <= rad_next;
            width_reg      <= width_next;
            height_reg     <= height_next;
            cnt_reg        <= cnt_next;
            surv_reg       <= surv_next;
            idx_reg        <= idx_next;
            drop_reg       <= drop_next;
            fetching_reg   <= fetching_next;
            pend_reg       <= pend_next;
            scan_reg       <= scan_next;
            sx_reg         <= sx_next;
            sy_reg         <= sy_next;
            have_prev_reg  <= have_prev_next;
            best_found_reg <= best_found_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        prev_key_reg  <= prev_key_next;
        best_key_reg  <= best_key_next;
        best_x_reg    <= best_x_next;
        best_y_reg    <= best_y_next;
        x0_reg        <= x0_next;
        x1_reg        <= x1_next;
        y1_reg        <= y1_next;
        xx_reg        <= xx_next;
        yy_reg        <= yy_next;
        fx_reg        <= fx_next;
        fy_reg        <= fy_next;
        look_r_reg    <= look_r_next;
        res_has_reg   <= res_has_next;
        res_final_reg <= res_final_next;
        m_has_reg     <= m_has_next;
        m_x_reg       <= m_x_next;
        m_y_reg       <= m_y_next;
        m_r_reg       <= m_r_next;
        m_final_reg   <= m_final_next;
        m_ovf_reg     <= m_ovf_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_has_survivor   = m_has_reg;
    assign m_kept_x         = m_x_reg;
    assign m_kept_y         = m_y_reg;
    assign m_kept_response  = m_r_reg;
    assign m_final_survivor = m_final_reg;
    assign m_overflowed     = m_ovf_reg;

    a_surv_within_count: assert property (@(posedge aclk) disable iff (!aresetn)
        surv_reg <= cnt_reg)
        else $error("survivor count exceeds stored points");

    a_count_within_store: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNTW'(MAX_KEYPOINTS))
        else $error("point count beyond store depth");

    a_no_surv_while_loading: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == gknms_pkg::ST_IDLE && !fetching_reg) |-> surv_reg == '0)
        else $error("survivors pending outside fetch phase");

    a_plain_load_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_opcode == gknms_pkg::OP_LOAD && !s_last)
        |=> state_reg == gknms_pkg::ST_IDLE)
        else $error("plain load did not return to idle");

endmodule
